/* sv/ted_pkg.sv */
// Package for the terminal escape decoder: parse phases, command codes,
// character codes and argument biases. No dependencies.
package ted_pkg;

  typedef enum logic [3:0] {
    PH_NORMAL  = 4'd0,
    PH_ESC     = 4'd1,
    PH_FILL_FG = 4'd2,
    PH_FILL_BG = 4'd3,
    PH_DISP_FG = 4'd4,
    PH_DISP_BG = 4'd5,
    PH_ROW     = 4'd6,
    PH_COL     = 4'd7,
    PH_REP_CNT = 4'd8,
    PH_REP_CHR = 4'd9,
    PH_CURSOR  = 4'd10
  } phase_t;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_NONE       = 5'd0;
  localparam cmd_t CMD_PRINT      = 5'd1;
  localparam cmd_t CMD_BELL       = 5'd2;
  localparam cmd_t CMD_BS         = 5'd3;
  localparam cmd_t CMD_TAB        = 5'd4;
  localparam cmd_t CMD_LF         = 5'd5;
  localparam cmd_t CMD_FF         = 5'd6;
  localparam cmd_t CMD_CR         = 5'd7;
  localparam cmd_t CMD_UP         = 5'd8;
  localparam cmd_t CMD_DOWN       = 5'd9;
  localparam cmd_t CMD_RIGHT      = 5'd10;
  localparam cmd_t CMD_LEFT       = 5'd11;
  localparam cmd_t CMD_INS_LINE   = 5'd12;
  localparam cmd_t CMD_DEL_LINE   = 5'd13;
  localparam cmd_t CMD_HOME       = 5'd14;
  localparam cmd_t CMD_REV_LF     = 5'd15;
  localparam cmd_t CMD_CLR_EOS    = 5'd16;
  localparam cmd_t CMD_CLR_EOL    = 5'd17;
  localparam cmd_t CMD_INS_SPACE  = 5'd18;
  localparam cmd_t CMD_DEL_CHAR   = 5'd19;
  localparam cmd_t CMD_PRINT_ON   = 5'd20;
  localparam cmd_t CMD_PRINT_OFF  = 5'd21;
  localparam cmd_t CMD_WRAP_ON    = 5'd22;
  localparam cmd_t CMD_WRAP_OFF   = 5'd23;
  localparam cmd_t CMD_GOTO       = 5'd24;
  localparam cmd_t CMD_REPEAT     = 5'd25;
  localparam cmd_t CMD_CURSOR     = 5'd26;
  localparam cmd_t CMD_SAVE       = 5'd27;
  localparam cmd_t CMD_RESTORE    = 5'd28;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam logic [8:0] POS_BIAS = 9'd31;
  localparam logic [8:0] REP_BIAS = 9'd32;

  localparam logic [3:0] ATTR_BOLD  = 4'b0001;
  localparam logic [3:0] ATTR_REV   = 4'b0010;
  localparam logic [3:0] ATTR_ULINE = 4'b0100;
  localparam logic [3:0] ATTR_BLINK = 4'b1000;

  localparam logic [6:0] COLOUR_RESET = 7'd7;

endpackage

/* sv/ted_ifs.sv */
// Channel interfaces of the terminal escape decoder: received byte in,
// decoded command out. Depends on nothing.
interface ted_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ted_cmd_if;
  logic              valid;
  logic              ready;
  logic [4:0]        command;
  logic              wrap_flag;
  logic signed [8:0] arg_first;
  logic signed [8:0] arg_second;
  logic [3:0]        attr_flags;
  logic [6:0]        display_color;
  logic [6:0]        fill_color;

  modport source (output valid, output command, output wrap_flag, output arg_first,
                  output arg_second, output attr_flags, output display_color,
                  output fill_color, input ready);
  modport sink   (input valid, input command, input wrap_flag, input arg_first,
                  input arg_second, input attr_flags, input display_color,
                  input fill_color, output ready);
endinterface

/* sv/terminal_escape_decoder_core.sv */
// Terminal escape decoder top level.
// Depends on ted_pkg and the channel interfaces in ted_ifs.sv.
//
// Takes one received byte per item on byte_ch and gives exactly one command
// item per byte on cmd_ch, in order. Throughput is one item per clock while
// cmd_ch is ready: a byte is held in an input register, is decoded against
// the parser state in one shallow pass, and the command lands in an output
// register, where the result is presented until cmd_ch takes it.
// The parser state (phase, held argument byte, attributes, colours and
// the save slot) updates in the same cycle the command is registered, so
// the next byte sees it at once. Both stages stall together when cmd_ch
// is not ready; a held result never blocks the byte already in the input
// register from being taken as soon as the output moves. The debug_session
// register (cfg_we/cfg_wdata) suppresses all actions except clear to end
// of screen and the graphic print after ESC; argument bytes are still
// consumed. No clearing pass: reset acts on the registers directly.
module terminal_escape_decoder_core (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  ted_byte_if.sink  byte_ch,
  ted_cmd_if.source cmd_ch
);

  // config
  logic debug_session;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_char;

  // parser state
  ted_pkg::phase_t phase, phase_next;
  logic [7:0] held_arg, held_arg_next;
  logic [3:0] attr, attr_next;
  logic [6:0] disp_col, disp_col_next;
  logic [6:0] fill_col, fill_col_next;
  logic [3:0] saved_attr, saved_attr_next;
  logic [6:0] saved_disp, saved_disp_next;
  logic [6:0] saved_fill, saved_fill_next;

  // decode results
  ted_pkg::cmd_t     cmd_d;
  logic              wrap_d;
  logic signed [8:0] a1_d, a2_d;

  // letter decode
  ted_pkg::phase_t let_phase;
  ted_pkg::cmd_t   let_cmd;
  logic [3:0]      let_set, let_clr, attr_upd;
  logic            let_wrap;

  // output stage
  logic out_valid;
  logic adv;

  // '0'..'7' only: top five bits must be those of '0'
  function automatic logic is_colour_digit(input logic [7:0] c);
    return c[7:3] == ted_pkg::CH_ZERO[7:3];
  endfunction

  assign adv          = s1_valid && (!out_valid || cmd_ch.ready);
  assign byte_ch.ready = !s1_valid || adv;
  assign cmd_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      debug_session <= 1'b0;
    end else if (cfg_we) begin
      debug_session <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
    if (byte_ch.valid && byte_ch.ready) begin
      s1_char <= byte_ch.char_code;
    end
  end

  // Sequence letter table: next phase, command, attribute set/clear.
  always_comb begin
    let_phase = ted_pkg::PH_NORMAL;
    let_cmd   = ted_pkg::CMD_NONE;
    let_set   = 4'd0;
    let_clr   = 4'd0;
    let_wrap  = 1'b0;
    case (s1_char)
      "!": let_phase = ted_pkg::PH_FILL_FG;
      "@": let_phase = ted_pkg::PH_DISP_FG;
      "=", "Y": let_phase = ted_pkg::PH_ROW;
      "g": let_phase = ted_pkg::PH_REP_CNT;
      "y": let_phase = ted_pkg::PH_CURSOR;
      "(": let_set = ted_pkg::ATTR_REV;
      ")": let_clr = ted_pkg::ATTR_REV;
      "<": let_set = ted_pkg::ATTR_BOLD;
      ">": let_clr = ted_pkg::ATTR_BOLD;
      "[": let_set = ted_pkg::ATTR_ULINE;
      "]": let_clr = ted_pkg::ATTR_ULINE;
      "{": let_set = ted_pkg::ATTR_BLINK;
      "}": let_clr = ted_pkg::ATTR_BLINK;
      "A": let_cmd = ted_pkg::CMD_UP;
      "B": let_cmd = ted_pkg::CMD_DOWN;
      "C": let_cmd = ted_pkg::CMD_RIGHT;
      "D": let_cmd = ted_pkg::CMD_LEFT;
      "a": begin
        let_cmd  = ted_pkg::CMD_UP;
        let_wrap = 1'b1;
      end
      "b": begin
        let_cmd  = ted_pkg::CMD_DOWN;
        let_wrap = 1'b1;
      end
      "c": begin
        let_cmd  = ted_pkg::CMD_RIGHT;
        let_wrap = 1'b1;
      end
      "d": begin
        let_cmd  = ted_pkg::CMD_LEFT;
        let_wrap = 1'b1;
      end
      "E": let_cmd = ted_pkg::CMD_INS_LINE;
      "F": let_cmd = ted_pkg::CMD_DEL_LINE;
      "H": let_cmd = ted_pkg::CMD_HOME;
      "I": let_cmd = ted_pkg::CMD_REV_LF;
      "J": let_cmd = ted_pkg::CMD_CLR_EOS;
      "K": let_cmd = ted_pkg::CMD_CLR_EOL;
      "e": let_cmd = ted_pkg::CMD_INS_SPACE;
      "f": let_cmd = ted_pkg::CMD_DEL_CHAR;
      "W": let_cmd = ted_pkg::CMD_PRINT_ON;
      "X": let_cmd = ted_pkg::CMD_PRINT_OFF;
      "h": let_cmd = ted_pkg::CMD_WRAP_ON;
      "i": let_cmd = ted_pkg::CMD_WRAP_OFF;
      "S": let_cmd = ted_pkg::CMD_SAVE;
      "R": let_cmd = ted_pkg::CMD_RESTORE;
      default: let_cmd = ted_pkg::CMD_NONE;
    endcase
  end

  assign attr_upd = (attr | let_set) & ~let_clr;

  // Main decode: one byte against the current parser state.
  always_comb begin
    phase_next      = ted_pkg::PH_NORMAL;
    held_arg_next   = held_arg;
    attr_next       = attr;
    disp_col_next   = disp_col;
    fill_col_next   = fill_col;
    saved_attr_next = saved_attr;
    saved_disp_next = saved_disp;
    saved_fill_next = saved_fill;
    cmd_d  = ted_pkg::CMD_NONE;
    wrap_d = 1'b0;
    a1_d   = 9'sd0;
    a2_d   = 9'sd0;
    case (phase)
      ted_pkg::PH_ESC: begin
        if (s1_char <= ted_pkg::CH_SPACE) begin
          // graphic print, also in debug mode
          cmd_d = ted_pkg::CMD_PRINT;
          a1_d  = {1'b0, s1_char};
        end else begin
          phase_next = let_phase;
          if (let_cmd == ted_pkg::CMD_CLR_EOS) begin
            cmd_d = ted_pkg::CMD_CLR_EOS;
          end else if (!debug_session) begin
            cmd_d     = let_cmd;
            wrap_d    = let_wrap;
            attr_next = attr_upd;
            if (let_cmd == ted_pkg::CMD_SAVE) begin
              saved_attr_next = attr_upd;
              saved_disp_next = disp_col;
              saved_fill_next = fill_col;
            end else if (let_cmd == ted_pkg::CMD_RESTORE) begin
              attr_next     = saved_attr;
              disp_col_next = saved_disp;
              fill_col_next = saved_fill;
            end
          end
        end
      end
      ted_pkg::PH_FILL_FG: begin
        held_arg_next = s1_char;
        phase_next    = ted_pkg::PH_FILL_BG;
      end
      ted_pkg::PH_DISP_FG: begin
        held_arg_next = s1_char;
        phase_next    = ted_pkg::PH_DISP_BG;
      end
      ted_pkg::PH_ROW: begin
        held_arg_next = s1_char;
        phase_next    = ted_pkg::PH_COL;
      end
      ted_pkg::PH_REP_CNT: begin
        held_arg_next = s1_char;
        phase_next    = ted_pkg::PH_REP_CHR;
      end
      ted_pkg::PH_FILL_BG: begin
        if (!debug_session && is_colour_digit(held_arg) && is_colour_digit(s1_char)) begin
          fill_col_next = {s1_char[2:0], 1'b0, held_arg[2:0]};
        end
      end
      ted_pkg::PH_DISP_BG: begin
        if (!debug_session && is_colour_digit(held_arg) && is_colour_digit(s1_char)) begin
          disp_col_next = {s1_char[2:0], 1'b0, held_arg[2:0]};
        end
      end
      ted_pkg::PH_COL: begin
        if (!debug_session) begin
          cmd_d = ted_pkg::CMD_GOTO;
          a1_d  = {1'b0, held_arg} - ted_pkg::POS_BIAS;
          a2_d  = {1'b0, s1_char} - ted_pkg::POS_BIAS;
        end
      end
      ted_pkg::PH_REP_CHR: begin
        if (!debug_session) begin
          cmd_d = ted_pkg::CMD_REPEAT;
          a1_d  = {1'b0, held_arg} - ted_pkg::REP_BIAS;
          a2_d  = {1'b0, s1_char};
        end
      end
      ted_pkg::PH_CURSOR: begin
        if (!debug_session && s1_char >= ted_pkg::CH_ZERO && s1_char <= ted_pkg::CH_TWO) begin
          cmd_d = ted_pkg::CMD_CURSOR;
          a1_d  = {1'b0, s1_char - ted_pkg::CH_ZERO};
        end
      end
      default: begin
        if (s1_char == ted_pkg::CH_ESC) begin
          phase_next = ted_pkg::PH_ESC;
        end else if (s1_char < ted_pkg::CH_SPACE || s1_char == ted_pkg::CH_DEL) begin
          if (!debug_session) begin
            case (s1_char)
              ted_pkg::CH_BEL: cmd_d = ted_pkg::CMD_BELL;
              ted_pkg::CH_BS:  cmd_d = ted_pkg::CMD_BS;
              ted_pkg::CH_TAB: cmd_d = ted_pkg::CMD_TAB;
              ted_pkg::CH_LF:  cmd_d = ted_pkg::CMD_LF;
              ted_pkg::CH_FF:  cmd_d = ted_pkg::CMD_FF;
              ted_pkg::CH_CR:  cmd_d = ted_pkg::CMD_CR;
              default:         cmd_d = ted_pkg::CMD_NONE;
            endcase
          end
        end else if (!debug_session) begin
          cmd_d = ted_pkg::CMD_PRINT;
          a1_d  = {1'b0, s1_char};
        end
      end
    endcase
  end

  // Parser state commits with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ted_pkg::PH_NORMAL;
      held_arg   <= 8'd0;
      attr       <= 4'd0;
      disp_col   <= ted_pkg::COLOUR_RESET;
      fill_col   <= ted_pkg::COLOUR_RESET;
      saved_attr <= 4'd0;
      saved_disp <= ted_pkg::COLOUR_RESET;
      saved_fill <= ted_pkg::COLOUR_RESET;
    end else if (adv) begin
      phase      <= phase_next;
      held_arg   <= held_arg_next;
      attr       <= attr_next;
      disp_col   <= disp_col_next;
      fill_col   <= fill_col_next;
      saved_attr <= saved_attr_next;
      saved_disp <= saved_disp_next;
      saved_fill <= saved_fill_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (cmd_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      cmd_ch.command       <= cmd_d;
      cmd_ch.wrap_flag     <= wrap_d;
      cmd_ch.arg_first     <= a1_d;
      cmd_ch.arg_second    <= a2_d;
      cmd_ch.attr_flags    <= attr_next;
      cmd_ch.display_color <= disp_col_next;
      cmd_ch.fill_color    <= fill_col_next;
    end
  end

endmodule

/* sv/ted_checker.sv */
// Port-level checker for the terminal escape decoder, bound to the top.
// Depends on ted_pkg and terminal_escape_decoder_core.
module ted_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] command,
  input logic       wrap_flag,
  input logic [8:0] arg_second,
  input logic [6:0] display_color,
  input logic [6:0] fill_color
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command))
    else $error("result dropped or changed while stalled");

  // an accepted byte reaches the output if the sink is ready while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

  // wrap only on cursor moves
  a_wrap_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && wrap_flag |->
      command == ted_pkg::CMD_UP || command == ted_pkg::CMD_DOWN ||
      command == ted_pkg::CMD_RIGHT || command == ted_pkg::CMD_LEFT)
    else $error("wrap flag on a non-move command");

  // second argument only for goto and repeat
  a_arg2: assert property (@(posedge clk) disable iff (rst)
    out_valid && arg_second != 9'd0 |->
      command == ted_pkg::CMD_GOTO || command == ted_pkg::CMD_REPEAT)
    else $error("second argument on wrong command");

  // colour layout keeps bit 3 clear
  a_colour: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !display_color[3] && !fill_color[3])
    else $error("colour bit 3 set");

endmodule

bind terminal_escape_decoder_core ted_checker u_ted_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_ch.valid),
  .in_ready      (byte_ch.ready),
  .out_valid     (cmd_ch.valid),
  .out_ready     (cmd_ch.ready),
  .command       (cmd_ch.command),
  .wrap_flag     (cmd_ch.wrap_flag),
  .arg_second    (cmd_ch.arg_second),
  .display_color (cmd_ch.display_color),
  .fill_color    (cmd_ch.fill_color)
);
